// ----- src/racst_pkg.sv -----
// ----------------------------------------------------------------------------
// racst_pkg
// Shared constants and types for the range add / clear / sum tree core.
// ----------------------------------------------------------------------------
package racst_pkg;

  localparam int LEAVES    = 1024;
  localparam int LOG_LEAVES = $clog2(LEAVES);
  localparam int NODES     = 2 * LEAVES;
  localparam int NW        = $clog2(NODES);
  localparam int LVLW      = $clog2(LOG_LEAVES + 1);
  localparam int IDXW      = 10;
  localparam int VALW      = 30;

  localparam logic [VALW-1:0] MODULUS   = 30'd998244353;
  localparam logic [VALW:0]   MODULUS_W = 31'd998244353;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_SUM   = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // clr and tag describe what is still owed to the children:
  // clear them first, then add tag to each child's sum
  typedef struct packed {
    logic            clr;
    logic [VALW-1:0] tag;
    logic [VALW-1:0] sum;
  } node_t;

endpackage

// ----- src/range_add_clear_sum_tree_core.sv -----
// ----------------------------------------------------------------------------
// range_add_clear_sum_tree_core
// Lazy segment tree over LEAVES residues mod 998244353 held in one
// synchronous node memory; range add, range clear and range sum.
// ----------------------------------------------------------------------------
// flow: push pending clears and tags down the left and right boundary paths,
//   add to, clear or sum each covered node, and after an update pull sums back up;
//   an empty query returns zero at once, an empty update returns the root sum
// throughput: one item at a time; next item taken once the result is registered
// reset: a clearing pass writes all 2*LEAVES nodes, one per cycle, with no
//   transfer accepted until it ends
module range_add_clear_sum_tree_core
  import racst_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      mode,
  input  logic [IDXW-1:0] range_low,
  input  logic [IDXW-1:0] range_high,
  input  logic [VALW-1:0] add_value,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [VALW-1:0] sum_value
);

  typedef enum logic [17:0] {
    S_CLR    = 18'b000000000000000001,
    S_IDLE   = 18'b000000000000000010,
    S_PS_SEL = 18'b000000000000000100,
    S_PS_RL  = 18'b000000000000001000,
    S_PS_RR  = 18'b000000000000010000,
    S_PS_WL  = 18'b000000000000100000,
    S_PS_WR  = 18'b000000000001000000,
    S_PS_WK  = 18'b000000000010000000,
    S_PS_NXT = 18'b000000000100000000,
    S_AP_CHK = 18'b000000001000000000,
    S_AP_WT  = 18'b000000010000000000,
    S_PL_SEL = 18'b000000100000000000,
    S_PL_R1  = 18'b000001000000000000,
    S_PL_W   = 18'b000010000000000000,
    S_PL_NXT = 18'b000100000000000000,
    S_ROOT   = 18'b001000000000000000,
    S_RWAIT  = 18'b010000000000000000,
    S_FIN    = 18'b100000000000000000
  } state_t;

  function automatic logic [VALW-1:0] madd(input logic [VALW-1:0] a,
                                           input logic [VALW-1:0] b);
    logic [VALW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= MODULUS_W) ? VALW'(s - MODULUS_W) : VALW'(s);
  endfunction

  function automatic logic [VALW-1:0] mhalf(input logic [VALW-1:0] x);
    logic [VALW:0] t;
    t = x[0] ? ({1'b0, x} + MODULUS_W) : {1'b0, x};
    return t[VALW:1];
  endfunction

  function automatic node_t napply(input logic c, input logic [VALW-1:0] t,
                                   input node_t x);
    node_t y;
    y.clr = c | x.clr;
    y.sum = madd(c ? '0 : x.sum, t);
    y.tag = madd(c ? '0 : x.tag, mhalf(t));
    return y;
  endfunction

  node_t mem [NODES];
  node_t rdata;
  logic [NW-1:0] raddr;
  logic [NW-1:0] waddr;
  logic          we;
  node_t         wdata;

  state_t          state;
  logic [NW-1:0]   clr_cnt;
  logic [1:0]      op_mode;
  logic [VALW-1:0] vred;
  logic [NW-1:0]   lreg;
  logic [NW:0]     rreg;
  logic [NW:0]     lw;
  logic [NW:0]     rw;
  logic [LVLW-1:0] lvl;
  logic            side;
  logic [NW-1:0]   kreg;
  node_t           par;
  node_t           lch;
  node_t           rch;
  logic [VALW-1:0] vl;
  logic [VALW-1:0] acc;

  logic [NW-1:0]   ql;
  logic [NW-1:0]   qr;
  logic [NW-1:0]   bnode;
  logic            bcond;
  logic [NW-1:0]   kleft;

  assign ql = ({1'b0, range_low} > NW'(LEAVES - 1)) ? NW'(LEAVES - 1) : {1'b0, range_low};
  assign qr = ({1'b0, range_high} > NW'(LEAVES - 1)) ? NW'(LEAVES - 1) : {1'b0, range_high};

  // boundary node of the current level on the left or right path
  always_comb begin
    if (side) begin
      bnode = NW'((rreg - 1'b1) >> lvl);
      bcond = (rreg != ((rreg >> lvl) << lvl));
    end else begin
      bnode = NW'(lreg >> lvl);
      bcond = (lreg != NW'((lreg >> lvl) << lvl));
    end
  end

  assign kleft    = NW'(kreg << 1);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      S_PS_SEL: raddr = bnode;
      S_PS_RL:  raddr = kleft;
      S_PS_RR:  raddr = kleft | NW'(1);
      S_PS_WL: begin
        we    = 1'b1;
        waddr = kleft;
        wdata = napply(par.clr, par.tag, lch);
      end
      S_PS_WR: begin
        we    = 1'b1;
        waddr = kleft | NW'(1);
        wdata = napply(par.clr, par.tag, rch);
      end
      S_PS_WK: begin
        we        = 1'b1;
        waddr     = kreg;
        wdata.sum = par.sum;
      end
      S_AP_CHK: raddr = lw[0] ? NW'(lw) : NW'(rw - 1'b1);
      S_AP_WT: begin
        if (op_mode != MODE_SUM) begin
          we    = 1'b1;
          waddr = kreg;
          wdata = napply(op_mode == MODE_CLEAR, (op_mode == MODE_CLEAR) ? '0 : vl, rdata);
        end
      end
      S_PL_SEL: raddr = NW'(bnode << 1);
      S_PL_R1:  raddr = kleft | NW'(1);
      S_PL_W: begin
        we        = 1'b1;
        waddr     = kreg;
        wdata.sum = madd(lch.sum, rdata.sum);
      end
      S_ROOT: raddr = NW'(1);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == NW'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_mode <= mode;
            vred    <= (add_value >= MODULUS) ? add_value - MODULUS : add_value;
            lreg    <= NW'(LEAVES) + ql;
            rreg    <= (NW+1)'(LEAVES) + {1'b0, qr} + 1'b1;
            acc     <= '0;
            lvl     <= LVLW'(LOG_LEAVES);
            side    <= 1'b0;
            if (mode != MODE_NOP && ql <= qr) begin
              state <= S_PS_SEL;
            end else if (mode == MODE_SUM) begin
              state <= S_FIN;
            end else begin
              state <= S_ROOT;
            end
          end
        end
        S_PS_SEL: begin
          kreg  <= bnode;
          state <= bcond ? S_PS_RL : S_PS_NXT;
        end
        S_PS_RL: begin
          par   <= rdata;
          state <= S_PS_RR;
        end
        S_PS_RR: begin
          lch   <= rdata;
          state <= (!par.clr && par.tag == '0) ? S_PS_NXT : S_PS_WL;
        end
        S_PS_WL: begin
          rch   <= rdata;
          state <= S_PS_WR;
        end
        S_PS_WR: state <= S_PS_WK;
        S_PS_WK: state <= S_PS_NXT;
        S_PS_NXT: begin
          side <= ~side;
          if (!side) begin
            state <= S_PS_SEL;
          end else if (lvl == LVLW'(1)) begin
            lw    <= {1'b0, lreg};
            rw    <= rreg;
            vl    <= vred;
            state <= S_AP_CHK;
          end else begin
            lvl   <= lvl - 1'b1;
            state <= S_PS_SEL;
          end
        end
        S_AP_CHK: begin
          if (lw >= rw) begin
            lvl   <= LVLW'(1);
            side  <= 1'b0;
            state <= (op_mode == MODE_SUM) ? S_FIN : S_PL_SEL;
          end else if (lw[0]) begin
            kreg  <= NW'(lw);
            lw    <= lw + 1'b1;
            state <= S_AP_WT;
          end else if (rw[0]) begin
            kreg  <= NW'(rw - 1'b1);
            rw    <= rw - 1'b1;
            state <= S_AP_WT;
          end else begin
            lw <= lw >> 1;
            rw <= rw >> 1;
            vl <= madd(vl, vl);
          end
        end
        S_AP_WT: begin
          if (op_mode == MODE_SUM) begin
            acc <= madd(acc, rdata.sum);
          end
          state <= S_AP_CHK;
        end
        S_PL_SEL: begin
          kreg  <= bnode;
          state <= bcond ? S_PL_R1 : S_PL_NXT;
        end
        S_PL_R1: begin
          lch   <= rdata;
          state <= S_PL_W;
        end
        S_PL_W: state <= S_PL_NXT;
        S_PL_NXT: begin
          side <= ~side;
          if (!side) begin
            state <= S_PL_SEL;
          end else if (lvl == LVLW'(LOG_LEAVES)) begin
            state <= S_ROOT;
          end else begin
            lvl   <= lvl + 1'b1;
            state <= S_PL_SEL;
          end
        end
        S_ROOT:  state <= S_RWAIT;
        S_RWAIT: begin
          acc   <= rdata.sum;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            sum_value <= acc;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/racst_checker.sv -----
// ----------------------------------------------------------------------------
// racst_checker
// Port-level checks for the range add / clear / sum tree core.
// ----------------------------------------------------------------------------
module racst_checker
  import racst_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [VALW-1:0] sum_value
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum_value))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sum_value < MODULUS)
    else $error("result not reduced");

  // one item in flight
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work in progress");

  // clearing pass after reset
  assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready during clearing pass");

endmodule

bind range_add_clear_sum_tree_core racst_checker u_racst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sum_value (sum_value)
);
